// ===== hdl/pnf_pkg.sv =====
`default_nettype none

package pnf_pkg;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 24;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int QFRAC      = 23;   // coefficient fraction bits
    localparam int LO_W       = 24;   // low chunk of a split operand
    localparam int NUM_POLES  = 6;
    localparam int POLE_IDX_W = 3;
    localparam int SCALE_W    = 16;
    localparam int OUT_SUM_W  = 42;   // clamped sum, +-2^40
    localparam int OUT_ACC_W  = OUT_SUM_W + SCALE_W + 1;

    typedef logic signed [MUL_B_W-1:0] t_coef;

    localparam t_coef DIRECT_COEF = 24'sd4497972;   // 0.5362
    localparam t_coef DELAY_COEF  = 24'sd972458;    // 0.115926

    // Multiplier issue codes
    typedef enum logic [2:0] {
        MOP_NONE,
        MOP_DIRECT,
        MOP_DELAY,
        MOP_FB_LO,
        MOP_FB_HI,
        MOP_IN,
        MOP_OUT_LO,
        MOP_OUT_HI
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_DELAY,
        ST_POLE,
        ST_DRAIN,
        ST_SUMUP,
        ST_CLAMP,
        ST_OUT_LO,
        ST_OUT_HI,
        ST_OUT_ACC,
        ST_FINAL
    } t_state;

    typedef struct packed {
        t_mop                  op;
        logic [POLE_IDX_W-1:0] pole;
        logic                  clamp;
        logic                  fin;
    } t_ctrl;

    function automatic t_coef fb_coef(input logic [POLE_IDX_W-1:0] k);
        t_coef c;
        case (k)
            3'd0:    c = 24'sd8379045;
            3'd1:    c = 24'sd8332572;
            3'd2:    c = 24'sd8128561;
            3'd3:    c = 24'sd7268729;
            3'd4:    c = 24'sd4613734;
            3'd5:    c = -24'sd6388764;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_coef in_coef(input logic [POLE_IDX_W-1:0] k);
        t_coef c;
        case (k)
            3'd0:    c = 24'sd465718;
            3'd1:    c = 24'sd629782;
            3'd2:    c = 24'sd1290604;
            3'd3:    c = 24'sd2604542;
            3'd4:    c = 24'sd4470727;
            3'd5:    c = -24'sd141751;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pnf_mul.sv =====
`default_nettype none

// Shared signed multiplier, product registered.
module pnf_mul (
    input  wire                                 i_clk,
    input  wire logic signed [pnf_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [pnf_pkg::MUL_B_W-1:0] i_b,
    output logic signed [pnf_pkg::PROD_W-1:0]   o_p
);
    import pnf_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== hdl/pnf_seq.sv =====
`default_nettype none

// Step sequencer: one multiplier issue per cycle, then sum, clamp and round.
module pnf_seq (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire            i_out_free,
    output logic           o_idle,
    output pnf_pkg::t_ctrl o_ctrl
);
    import pnf_pkg::*;

    localparam logic [1:0] PH_FB_LO = 2'd0;
    localparam logic [1:0] PH_FB_HI = 2'd1;
    localparam logic [1:0] PH_IN    = 2'd2;
    localparam logic [POLE_IDX_W-1:0] LAST_POLE = POLE_IDX_W'(NUM_POLES - 1);

    t_state                r_state, n_state;
    logic [POLE_IDX_W-1:0] r_pole, n_pole;
    logic [1:0]            r_phase, n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pole  <= '0;
            r_phase <= PH_FB_LO;
        end else begin
            r_state <= n_state;
            r_pole  <= n_pole;
            r_phase <= n_phase;
        end
    end

    // next state and step counters
    always_comb begin
        n_state = r_state;
        n_pole  = '0;
        n_phase = PH_FB_LO;
        unique case (r_state)
            ST_IDLE:    if (i_start) n_state = ST_DIRECT;
            ST_DIRECT:  n_state = ST_DELAY;
            ST_DELAY:   n_state = ST_POLE;
            ST_POLE: begin
                if (r_phase == PH_IN) begin
                    n_phase = PH_FB_LO;
                    n_pole  = r_pole + 1'b1;
                    if (r_pole == LAST_POLE) n_state = ST_DRAIN;
                end else begin
                    n_phase = r_phase + 1'b1;
                    n_pole  = r_pole;
                end
            end
            ST_DRAIN:   n_state = ST_SUMUP;
            ST_SUMUP:   n_state = ST_CLAMP;
            ST_CLAMP:   n_state = ST_OUT_LO;
            ST_OUT_LO:  n_state = ST_OUT_HI;
            ST_OUT_HI:  n_state = ST_OUT_ACC;
            ST_OUT_ACC: n_state = ST_FINAL;
            ST_FINAL:   if (i_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // step outputs
    always_comb begin
        o_ctrl.op    = MOP_NONE;
        o_ctrl.pole  = r_pole;
        o_ctrl.clamp = 1'b0;
        o_ctrl.fin   = 1'b0;
        unique case (r_state)
            ST_DIRECT: o_ctrl.op = MOP_DIRECT;
            ST_DELAY:  o_ctrl.op = MOP_DELAY;
            ST_POLE: begin
                case (r_phase)
                    PH_FB_LO: o_ctrl.op = MOP_FB_LO;
                    PH_FB_HI: o_ctrl.op = MOP_FB_HI;
                    default:  o_ctrl.op = MOP_IN;
                endcase
            end
            ST_CLAMP:  o_ctrl.clamp = 1'b1;
            ST_OUT_LO: o_ctrl.op = MOP_OUT_LO;
            ST_OUT_HI: o_ctrl.op = MOP_OUT_HI;
            ST_FINAL:  o_ctrl.fin = i_out_free;
            default:   o_ctrl.op = MOP_NONE;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/pink_noise_filter_unit.sv =====
`default_nettype none

// Pink noise filter: six one-pole sections plus a one-word delayed term.
// Slave stream: one white sample per word in i_s_tdata (Q1.15 by default).
// Master stream: one pink sample per word in o_m_tdata, saturation flag in
// o_m_tuser. output_scale (Q0.16) sits at byte address 0 of the APB port.
// Timing: a word is accepted only when the sequencer is idle; the result is
// registered as the sequencer returns to idle, and the slave side is ready
// again in that same cycle. The pace is set by a single 25x24 multiplier
// issuing 22 products (two per state product, two for the output gain),
// plus the sum, clamp and rounding steps.
// The output register parts the two sides: a new word is taken while an
// old result waits. If the receiver stalls so long that the next result is
// ready, the sequencer holds in its last step until the register frees.
// Reset (synchronous, active low) clears all filter state, the output valid
// and sets output_scale to 7209 (about 0.11).
module pink_noise_filter_unit #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    // slave stream
    input  wire                                         i_s_tvalid,
    output logic                                        o_s_tready,
    input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   i_s_tdata,  // [SW-1:0] white_sample
    // master stream
    output logic                                        o_m_tvalid,
    input  wire                                         i_m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   o_m_tdata,  // [SW-1:0] pink_sample
    output logic                                        o_m_tuser,  // [0] clipped
    // APB configuration
    input  wire                                         psel,
    input  wire                                         penable,
    input  wire                                         pwrite,
    input  wire  [2:0]                                  paddr,
    input  wire  [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready
);
    import pnf_pkg::*;

    localparam int TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int WQ_SHIFT  = MUL_A_W - SAMPLE_WIDTH;
    localparam int ACC_W     = (STATE_WIDTH + MUL_B_W > OUT_ACC_W) ?
                               STATE_WIDTH + MUL_B_W : OUT_ACC_W;
    localparam int RND_ACC_W = ACC_W - QFRAC;
    localparam int RND_P_W   = PROD_W - QFRAC;
    localparam int NEW_W     = RND_ACC_W + 1;
    localparam int SUM_W     = (STATE_WIDTH + 4 > OUT_SUM_W) ? STATE_WIDTH + 4 : OUT_SUM_W;
    localparam int OUT_SH    = 41 - SAMPLE_WIDTH;
    localparam int Y_W       = ACC_W - OUT_SH;

    localparam logic [0:0] REG_SCALE = 1'b0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd7209;

    localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << (QFRAC - 1);
    localparam logic signed [PROD_W-1:0] P_HALF   = PROD_W'(1) << (QFRAC - 1);
    localparam logic signed [ACC_W-1:0]  OUT_HALF = ACC_W'(1) << (OUT_SH - 1);
    localparam logic signed [NEW_W-1:0]  ST_MAX   = (NEW_W'(1) << (STATE_WIDTH - 1)) - 1'b1;
    localparam logic signed [NEW_W-1:0]  ST_MIN   = ~ST_MAX;
    localparam logic signed [SUM_W-1:0]  SUM_LIM  = SUM_W'(1) << 40;
    localparam logic signed [SUM_W-1:0]  SUM_NLIM = -SUM_LIM;
    localparam logic signed [Y_W-1:0]    Y_MAX    = (Y_W'(1) << (SAMPLE_WIDTH - 1)) - 1'b1;
    localparam logic signed [Y_W-1:0]    Y_MIN    = ~Y_MAX;

    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [NEW_W-1:0] v
    );
        logic signed [STATE_WIDTH-1:0] r;
        if (v > ST_MAX)      r = STATE_WIDTH'(ST_MAX);
        else if (v < ST_MIN) r = STATE_WIDTH'(ST_MIN);
        else                 r = STATE_WIDTH'(v);
        return r;
    endfunction

    // control
    t_ctrl                    w_ctrl;
    logic                     w_idle;
    logic                     w_start;
    logic                     w_out_free;
    logic                     w_cfg_wr;
    t_mop                     r_prev_op;
    logic [POLE_IDX_W-1:0]    r_prev_pole;
    logic                     r_pend;
    logic                     r_out_vld;
    logic [SCALE_W-1:0]       r_scale;

    // filter state and datapath
    logic signed [STATE_WIDTH-1:0] r_b [NUM_POLES];
    logic signed [STATE_WIDTH-1:0] r_delay;
    logic signed [STATE_WIDTH-1:0] r_new;
    logic signed [MUL_A_W-1:0]     r_wq;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic [SAMPLE_WIDTH-1:0]       r_pink;
    logic                          r_clip;

    logic signed [MUL_A_W-1:0]     w_a;
    logic signed [MUL_B_W-1:0]     w_b;
    logic signed [PROD_W-1:0]      w_p;
    logic signed [ACC_W-1:0]       w_p_ext;
    logic signed [RND_ACC_W-1:0]   w_acc_rnd;
    logic signed [RND_P_W-1:0]     w_p_rnd;
    logic signed [STATE_WIDTH-1:0] w_new_sat;
    logic signed [STATE_WIDTH-1:0] w_delay_sat;
    logic signed [Y_W-1:0]         w_y;
    logic [SAMPLE_WIDTH-1:0]       w_y_sat;
    logic                          w_y_clip;

    assign w_start    = i_s_tvalid && w_idle;
    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    pnf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_ctrl     (w_ctrl)
    );

    // operand select for the issue of this step
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (w_ctrl.op)
            MOP_DIRECT: begin
                w_a = r_wq;
                w_b = DIRECT_COEF;
            end
            MOP_DELAY: begin
                w_a = r_wq;
                w_b = DELAY_COEF;
            end
            MOP_FB_LO: begin
                w_a = signed'({1'b0, r_b[w_ctrl.pole][LO_W-1:0]});
                w_b = fb_coef(w_ctrl.pole);
            end
            MOP_FB_HI: begin
                w_a = MUL_A_W'(r_b[w_ctrl.pole] >>> LO_W);
                w_b = fb_coef(w_ctrl.pole);
            end
            MOP_IN: begin
                w_a = r_wq;
                w_b = in_coef(w_ctrl.pole);
            end
            MOP_OUT_LO: begin
                w_a = signed'({1'b0, r_sum[LO_W-1:0]});
                w_b = signed'({(MUL_B_W - SCALE_W)'(0), r_scale});
            end
            MOP_OUT_HI: begin
                w_a = MUL_A_W'(r_sum >>> LO_W);
                w_b = signed'({(MUL_B_W - SCALE_W)'(0), r_scale});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    pnf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    // rounding: add one half, arithmetic shift (floor)
    assign w_p_ext     = ACC_W'(w_p);
    assign w_acc_rnd   = RND_ACC_W'((r_acc + ACC_HALF) >>> QFRAC);
    assign w_p_rnd     = RND_P_W'((w_p + P_HALF) >>> QFRAC);
    assign w_new_sat   = sat_state(NEW_W'(w_acc_rnd) + NEW_W'(w_p_rnd));
    assign w_delay_sat = sat_state(NEW_W'(w_p_rnd));

    // output rounding and saturation
    assign w_y = Y_W'((r_acc + OUT_HALF) >>> OUT_SH);
    always_comb begin
        w_y_clip = 1'b0;
        w_y_sat  = SAMPLE_WIDTH'(w_y);
        if (w_y > Y_MAX) begin
            w_y_sat  = SAMPLE_WIDTH'(Y_MAX);
            w_y_clip = 1'b1;
        end else if (w_y < Y_MIN) begin
            w_y_sat  = SAMPLE_WIDTH'(Y_MIN);
            w_y_clip = 1'b1;
        end
    end

    // product accumulator: split products are joined here
    always_comb begin
        n_acc = r_acc;
        case (r_prev_op) inside
            MOP_FB_LO, MOP_OUT_LO: n_acc = w_p_ext;
            MOP_FB_HI, MOP_OUT_HI: n_acc = r_acc + (w_p_ext <<< LO_W);
            default:               n_acc = r_acc;
        endcase
    end

    // running sum, seeded with the old delayed term
    always_comb begin
        n_sum = r_sum;
        if (w_start) begin
            n_sum = SUM_W'(r_delay);
        end else if (w_ctrl.clamp) begin
            if (r_sum > SUM_LIM)       n_sum = SUM_LIM;
            else if (r_sum < SUM_NLIM) n_sum = SUM_NLIM;
        end else if (r_prev_op == MOP_DIRECT) begin
            n_sum = r_sum + SUM_W'(w_p_rnd);
        end else if (r_pend) begin
            n_sum = r_sum + SUM_W'(r_new);
        end
    end

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_op   <= MOP_NONE;
            r_prev_pole <= '0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_scale     <= SCALE_RESET;
            r_delay     <= '0;
            for (int i = 0; i < NUM_POLES; i++) begin
                r_b[i] <= '0;
            end
        end else begin
            r_prev_op   <= w_ctrl.op;
            r_prev_pole <= w_ctrl.pole;
            r_pend      <= (r_prev_op == MOP_IN);
            if (r_prev_op == MOP_IN) begin
                r_b[r_prev_pole] <= w_new_sat;
            end
            if (r_prev_op == MOP_DELAY) begin
                r_delay <= w_delay_sat;
            end
            if (w_ctrl.fin) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_cfg_wr && paddr[2] == REG_SCALE) begin
                r_scale <= pwdata[SCALE_W-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_wq <= signed'({i_s_tdata[SAMPLE_WIDTH-1:0], {WQ_SHIFT{1'b0}}});
        end
        r_sum <= n_sum;
        r_acc <= n_acc;
        if (r_prev_op == MOP_IN) begin
            r_new <= w_new_sat;
        end
        if (w_ctrl.fin) begin
            r_pink <= w_y_sat;
            r_clip <= w_y_clip;
        end
    end

    assign o_s_tready = w_idle;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = TDATA_W'(r_pink);
    assign o_m_tuser  = r_clip;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_SCALE) ? {(32 - SCALE_W)'(0), r_scale} : '0;

endmodule

`default_nettype wire

// ===== hdl/pnf_checker.sv =====
`default_nettype none

// Port-level checks on the pink noise filter.
module pnf_checker #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TDATA_W      = 16
) (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_s_tvalid,
    input wire               o_s_tready,
    input wire               o_m_tvalid,
    input wire               i_m_tready,
    input wire [TDATA_W-1:0] o_m_tdata,
    input wire               o_m_tuser
);

    localparam logic [SAMPLE_WIDTH-1:0] PMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] PMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    // one word in flight: slave side closes right after a take
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("slave side still ready after a word was taken");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // a clipped word sits at full scale
    a_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata[SAMPLE_WIDTH-1:0] == PMAX || o_m_tdata[SAMPLE_WIDTH-1:0] == PMIN))
        else $error("clip flag on a word below full scale");

    // reset leaves no result and an open slave side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("state not cleared by reset");

endmodule

bind pink_noise_filter_unit pnf_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TDATA_W      (((SAMPLE_WIDTH + 7) / 8) * 8)
) u_pnf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== tb/sv/pink_noise_filter_unit_tb.sv =====
module pink_noise_filter_unit_tb;

    localparam int SW        = 16;
    localparam int STW       = 32;
    localparam int BUS_W     = ((SW + 7) / 8) * 8;
    localparam int NPOLE     = pnf_pkg::NUM_POLES;
    localparam int WATCHDOG  = 3000;   // cycles with no word moving on either stream
    localparam int TAIL_WAIT = 40;     // margin past the result latency

    localparam logic [2:0]  ADDR_OUTPUT_SCALE = 3'd0;
    localparam logic [2:0]  ADDR_UNMAPPED     = 3'd4;
    localparam logic [15:0] GAIN_RESET        = 16'd7209;
    localparam logic [15:0] GAIN_MAX          = 16'hFFFF;

    localparam logic signed [SW-1:0] WHITE_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] WHITE_MIN = {1'b1, {(SW - 1){1'b0}}};

    // fixed-point bounds: state Q.24, coefficients Q1.23
    localparam int     OUT_SHIFT  = 41 - SW;
    localparam longint HALF_Q23   = 64'sd1 <<< 22;
    localparam longint HALF_OUT   = 64'sd1 <<< (OUT_SHIFT - 1);
    localparam longint SUM_LIMIT  = 64'sd1 <<< 40;
    localparam longint STATE_MAX  = (64'sd1 <<< (STW - 1)) - 1;
    localparam longint STATE_MIN  = -(64'sd1 <<< (STW - 1));
    localparam longint PINK_MAX   = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint PINK_MIN   = -(64'sd1 <<< (SW - 1));
    localparam longint DIRECT_Q23 = 64'sd4497972;   // 0.5362
    localparam longint DELAY_Q23  = 64'sd972458;    // 0.115926

    typedef struct packed {
        logic [SW-1:0] pink;
        logic          clipped;
    } t_pink_word;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [BUS_W-1:0] i_s_tdata  = '0;    // [SW-1:0] white_sample
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [BUS_W-1:0] o_m_tdata;          // [SW-1:0] pink_sample
    logic             o_m_tuser;          // [0] clipped
    logic             psel       = 1'b0;
    logic             penable    = 1'b0;
    logic             pwrite     = 1'b0;
    logic [2:0]       paddr      = '0;
    logic [31:0]      pwdata     = '0;
    logic [31:0]      prdata;
    logic             pready;

    // filter state as the block should hold it
    longint      pole_q24 [NPOLE];
    longint      delay_q24;
    logic [15:0] gain_q16;
    t_pink_word  pink_expect_q [$];

    int err_count     = 0;
    int idle_cycles   = 0;
    int sink_hold_len = 0;
    bit src_jitter    = 1'b1;
    bit sink_jitter   = 1'b1;

    pink_noise_filter_unit #(
        .SAMPLE_WIDTH (SW),
        .STATE_WIDTH  (STW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint feedback_q23(input int k);
        case (k)
            0:       return 64'sd8379045;
            1:       return 64'sd8332572;
            2:       return 64'sd8128561;
            3:       return 64'sd7268729;
            4:       return 64'sd4613734;
            default: return -64'sd6388764;
        endcase
    endfunction

    function automatic longint input_q23(input int k);
        case (k)
            0:       return 64'sd465718;
            1:       return 64'sd629782;
            2:       return 64'sd1290604;
            3:       return 64'sd2604542;
            4:       return 64'sd4470727;
            default: return -64'sd141751;
        endcase
    endfunction

    // Q.24 x Q1.23, round half up back to Q.24; fits in 64 bits at these widths
    function automatic longint mul_q23_round(input longint a, input longint c);
        return (a * c + HALF_Q23) >>> 23;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Q.24 sum for one white sample; state only moves when commit is set
    function automatic longint filter_sum(input logic signed [SW-1:0] white, input bit commit);
        longint wq;
        longint acc;
        longint nxt;
        wq  = longint'(white) <<< (25 - SW);
        acc = 0;
        for (int k = 0; k < NPOLE; k++) begin
            nxt = clamp(mul_q23_round(pole_q24[k], feedback_q23(k)) +
                        mul_q23_round(wq, input_q23(k)), STATE_MIN, STATE_MAX);
            acc += nxt;
            if (commit) pole_q24[k] = nxt;
        end
        // the delayed term enters with its old value
        acc += delay_q24 + mul_q23_round(wq, DIRECT_Q23);
        if (commit) delay_q24 = clamp(mul_q23_round(wq, DELAY_Q23), STATE_MIN, STATE_MAX);
        return acc;
    endfunction

    // scaled and rounded output before saturation
    function automatic longint pink_unsat(input longint acc, input longint gain);
        return (clamp(acc, -SUM_LIMIT, SUM_LIMIT) * gain + HALF_OUT) >>> OUT_SHIFT;
    endfunction

    function automatic t_pink_word scale_pink(input longint acc, input logic [15:0] gain);
        t_pink_word r;
        longint     y;
        y         = pink_unsat(acc, longint'(gain));
        r.clipped = (y > PINK_MAX) || (y < PINK_MIN);
        y         = clamp(y, PINK_MIN, PINK_MAX);
        r.pink    = y[SW-1:0];
        return r;
    endfunction

    // gain that lands the next output exactly on target (plus or minus one)
    function automatic logic [15:0] gain_for_edge(input longint acc, input longint target);
        longint base;
        if (acc == 0) return GAIN_RESET;
        base = ((PINK_MAX + 1) <<< OUT_SHIFT) / ((acc < 0) ? -acc : acc);
        for (longint g = base - 3; g <= base + 3; g++) begin
            if (g >= 0 && g <= longint'(GAIN_MAX) && pink_unsat(acc, g) == target)
                return g[15:0];
        end
        return (base > longint'(GAIN_MAX)) ? GAIN_MAX : base[15:0];
    endfunction

    function automatic logic signed [SW-1:0] pick_white();
        logic signed [5:0] tiny;
        tiny = 6'($urandom);
        case ($urandom_range(0, 7))
            0:       return WHITE_MAX;
            1:       return WHITE_MIN;
            2:       return tiny;
            default: return SW'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_error(input string what, input longint want, input longint got);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0t %s: expected %0d got %0d", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_pink_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pink_expect_q.size() == 0) begin
                flag_error("unexpected pink word", 0, $signed(o_m_tdata[SW-1:0]));
            end else begin
                want = pink_expect_q.pop_front();
                if (o_m_tdata[SW-1:0] !== want.pink)
                    flag_error("pink_sample", $signed(want.pink), $signed(o_m_tdata[SW-1:0]));
                if (o_m_tuser !== want.clipped)
                    flag_error("clipped", want.clipped, o_m_tuser);
            end
        end
    end

    // stuck handshake guard
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial begin : sink_pacing
        forever begin
            if (sink_hold_len != 0) begin
                i_m_tready <= 1'b0;
                repeat (sink_hold_len) @(posedge i_clk);
                sink_hold_len = 0;
            end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // valid is left high on return so back-to-back words need no second NBA
    task automatic send_white(input logic signed [SW-1:0] white);
        logic [BUS_W-1:0] word;
        word          = '0;
        word[SW-1:0]  = white;
        if (src_jitter && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= BUS_W'($urandom);
            // half the gaps start only once the block is asking for a word
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (!o_s_tready);
            end
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        pink_expect_q.push_back(scale_pink(filter_sum(white, 1'b1), gain_q16));
    endtask

    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pink_expect_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_OUTPUT_SCALE) gain_q16 = data[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0, gain_q16})
            flag_error("output_scale readback", gain_q16, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // only between phases, once the block has nothing in flight
    task automatic set_gain(input logic [15:0] gain);
        logic [31:0] data;
        data       = $urandom;    // upper bits are not part of the register
        data[15:0] = gain;
        wait_results_drained();
        cfg_write(ADDR_OUTPUT_SCALE, data);
        cfg_read_check(ADDR_OUTPUT_SCALE);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_value();
        cfg_read_check(ADDR_OUTPUT_SCALE);
    endtask

    // Output of exactly plus one must clip; exactly minus one must not.
    task automatic test_unity_edges();
        // from the cleared filter a full-scale sample sums to about 1.65
        set_gain(gain_for_edge(filter_sum(WHITE_MAX, 1'b0), PINK_MAX + 1));
        send_white(WHITE_MAX);
        // one negative sample winds the poles so the next sums to about -1.96
        send_white(WHITE_MIN);
        set_gain(gain_for_edge(filter_sum(WHITE_MIN, 1'b0), PINK_MIN));
        send_white(WHITE_MIN);
    endtask

    task automatic test_gain_extremes();
        set_gain(GAIN_MAX);
        repeat (3) send_white(WHITE_MAX);
        repeat (3) send_white(WHITE_MIN);
        send_white('0);
        send_white(16'sd1);
        send_white(-16'sd1);
        send_white(16'sh5555);
        send_white(16'shAAAA);
        // a write past the only register must leave it alone
        wait_results_drained();
        cfg_write(ADDR_UNMAPPED, $urandom);
        cfg_read_check(ADDR_OUTPUT_SCALE);
        send_white(WHITE_MAX);
        send_white(WHITE_MIN);
        set_gain(GAIN_RESET);
        send_white('0);
        send_white(16'sd1);
        send_white(-16'sd1);
        send_white(16'sh4000);
        send_white(-16'sh4000);
    endtask

    // Phases at several gains; constant runs drive the slow poles deep.
    task automatic test_random_noise();
        logic [15:0]          gain;
        logic signed [SW-1:0] white;
        int                   sent;
        int                   run_len;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0:       gain = 16'd1;
                1:       gain = GAIN_MAX;
                2:       gain = '0;
                3:       gain = GAIN_RESET;
                default: gain = 16'($urandom);
            endcase
            set_gain(gain);
            sent = 0;
            while (sent < 130) begin
                white = pick_white();
                if ($urandom_range(0, 5) == 0) begin
                    run_len = $urandom_range(4, 40);
                    repeat (run_len) send_white(white);
                    sent += run_len;
                end else begin
                    send_white(white);
                    sent++;
                end
            end
        end
    endtask

    // receiver holds off long enough for the block to back up into the input
    task automatic test_sink_backpressure();
        wait_results_drained();
        src_jitter    = 1'b0;
        sink_hold_len = 300;
        repeat (40) send_white(pick_white());
        src_jitter    = 1'b1;
    endtask

    task automatic test_source_pause();
        repeat (20) send_white(pick_white());
        wait_results_drained();
        repeat (20) send_white(pick_white());
    endtask

    task automatic test_quiet_tail();
        wait_results_drained();
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        repeat (150) send_white(pick_white());
        wait_results_drained();
    endtask

    initial begin : run_tests
        for (int k = 0; k < NPOLE; k++) pole_q24[k] = 0;
        delay_q24 = 0;
        gain_q16  = GAIN_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_value();
        test_unity_edges();
        test_gain_extremes();
        test_random_noise();
        test_sink_backpressure();
        test_source_pause();
        test_quiet_tail();

        // catch any stray word after the last one expected
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pink_expect_q.size() != 0)
            flag_error("pink words outstanding", 0, pink_expect_q.size());
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
